@@ src/bilm_pkg.sv @@
// Package for the busy interval load meter: widths, command and status codes,
// and the struct types shared by the ring store, the divider and the top level.
// Depends on nothing.
package bilm_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int TIME_W     = 32;
  localparam int Q_W        = 16;
  localparam int Q_FRAC     = 12;
  localparam int SAT_SHIFT  = Q_W - Q_FRAC;
  localparam int CNT_W      = $clog2(Q_W);

  localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_STOP    = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] ST_DONE          = 2'd0;
  localparam logic [1:0] ST_START_IGNORED = 2'd1;
  localparam logic [1:0] ST_STOP_IGNORED  = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] time_now;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [Q_W-1:0] peak_load;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] stop_time;
  } ring_entry_t;

  typedef struct packed {
    logic        en;
    logic [IDX_W-1:0] addr;
    ring_entry_t data;
  } ring_wr_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ src/bilm_ring.sv @@
// Ring store of start/stop time pairs: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on bilm_pkg.
module bilm_ring import bilm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ring_wr_t         wr,
  input  logic [IDX_W-1:0] rd_addr,
  output ring_entry_t      rd
);

  ring_entry_t           mem [RING_DEPTH];
  ring_entry_t           rd_raw;
  logic [RING_DEPTH-1:0] valid;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd = rd_vld ? rd_raw : '0;

endmodule

@@ src/bilm_div.sv @@
// Serial restoring divider for the Q4.12 busy ratio: num * 4096 / den, saturated.
// One quotient bit per cycle, after a saturation check step.
// Depends on bilm_pkg.
module bilm_div import bilm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_STEP} dstate_t;

  dstate_t           state;
  logic [TIME_W-1:0] num;
  logic [TIME_W-1:0] den;
  logic [TIME_W-1:0] rem;
  logic [Q_W-1:0]    low;
  logic [Q_W-1:0]    quot;
  logic [CNT_W-1:0]  cnt;
  logic              done;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;
  logic              sat;

  assign trial = {rem, low[Q_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  // The quotient fits in Q_W bits only when num < den * 2^SAT_SHIFT.
  assign sat   = {{SAT_SHIFT{1'b0}}, num} >= {den, {SAT_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            num   <= req.num;
            den   <= req.den;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (sat) begin
            quot  <= Q_MAX;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            rem   <= num >> SAT_SHIFT;
            low   <= {num[SAT_SHIFT-1:0], {Q_FRAC{1'b0}}};
            quot  <= '0;
            cnt   <= '0;
            state <= D_STEP;
          end
        end
        D_STEP: begin
          rem  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
          quot <= {quot[Q_W-2:0], ge};
          low  <= {low[Q_W-2:0], 1'b0};
          if (cnt == CNT_W'(Q_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ src/busy_interval_load_meter_unit.sv @@
// Busy interval load meter: top-level sequencer, ring store and serial divider.
// Depends on bilm_pkg, bilm_ring and bilm_div.
//
// Usage:
// A request carries a command and the current microsecond time. Start latches
// the time, stop stores the open interval in a 16-entry ring, and compute walks
// the 15 adjacent entry pairs and keeps the largest busy-to-period ratio
// (unsigned Q4.12, saturated) as the peak. Every request yields exactly one
// response with a status code and the peak after that request.
// For start, stop and unused commands the sequencer goes from idle straight to
// the response state. A compute request first primes the ring read and loads
// entry 0; each following pair then takes a ring read wait, the difference
// terms and a check, and a pair that needs a division also waits in the
// divider (a saturation check, then the quotient bits unless it saturates).
// The block takes one request at a time: req_ready is high only while the
// sequencer is idle. A finished response sits in an output register, so the
// next request can be accepted while rsp_valid waits on a stalled rsp_ready;
// the following response then holds until the register frees.
// Reset clears the ring (by per-entry valid bits), the write index, the open
// interval flag, the latched start time and the peak; no clearing pass runs.
module busy_interval_load_meter_unit import bilm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRIME, S_LOAD0, S_WAIT, S_EVAL, S_CHECK, S_DIV, S_RESP
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  write_index;
  logic              running;
  logic [TIME_W-1:0] pending_start;
  logic [Q_W-1:0]    peak_ratio;
  logic [TIME_W-1:0] prev_start;
  logic [TIME_W-1:0] prev_stop;
  logic [TIME_W-1:0] busy_d;
  logic [TIME_W-1:0] gap_d;
  logic [1:0]        status;

  ring_wr_t          ring_wr;
  ring_entry_t       ring_rd;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              last_pair;
  logic              busy_neg;
  logic              gap_neg;
  logic              pair_div;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign last_pair = (idx == IDX_W'(RING_DEPTH - 1));

  assign ring_wr.en              = accept && (req.command == CMD_STOP) && running;
  assign ring_wr.addr            = write_index;
  assign ring_wr.data.start_time = pending_start;
  assign ring_wr.data.stop_time  = req.time_now;

  bilm_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr      (ring_wr),
    .rd_addr (idx),
    .rd      (ring_rd)
  );

  // Differences are read as signed; the divider sees magnitudes only.
  assign busy_neg    = busy_d[TIME_W-1];
  assign gap_neg     = gap_d[TIME_W-1];
  assign pair_div    = (gap_d != '0) && (busy_d != '0) && (busy_neg == gap_neg);
  assign div_req.start = (state == S_CHECK) && pair_div;
  assign div_req.num   = busy_neg ? (~busy_d + 1'b1) : busy_d;
  assign div_req.den   = gap_neg ? (~gap_d + 1'b1) : gap_d;

  bilm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      write_index   <= '0;
      running       <= 1'b0;
      pending_start <= '0;
      peak_ratio    <= '0;
      status        <= ST_DONE;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status <= ST_DONE;
            state  <= S_RESP;
            case (req.command)
              CMD_START: begin
                if (running) begin
                  status <= ST_START_IGNORED;
                end else begin
                  pending_start <= req.time_now;
                  running       <= 1'b1;
                end
              end
              CMD_STOP: begin
                if (!running) begin
                  status <= ST_STOP_IGNORED;
                end else begin
                  running <= 1'b0;
                  if (write_index == IDX_W'(RING_DEPTH - 1)) begin
                    write_index <= '0;
                    peak_ratio  <= '0;
                  end else begin
                    write_index <= write_index + 1'b1;
                  end
                end
              end
              CMD_COMPUTE: begin
                idx   <= '0;
                state <= S_PRIME;
              end
              default: ;
            endcase
          end
        end
        S_PRIME: state <= S_LOAD0;
        S_LOAD0: begin
          prev_start <= ring_rd.start_time;
          prev_stop  <= ring_rd.stop_time;
          idx        <= IDX_W'(1);
          state      <= S_WAIT;
        end
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          busy_d     <= prev_stop - prev_start;
          gap_d      <= ring_rd.start_time - prev_start;
          prev_start <= ring_rd.start_time;
          prev_stop  <= ring_rd.stop_time;
          state      <= S_CHECK;
        end
        S_CHECK: begin
          if (pair_div) begin
            state <= S_DIV;
          end else begin
            // A zero gap saturates unless the busy time is negative.
            if ((gap_d == '0) && !busy_neg) begin
              peak_ratio <= Q_MAX;
            end
            if (last_pair) begin
              state <= S_RESP;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_WAIT;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quot > peak_ratio) begin
              peak_ratio <= div_rsp.quot;
            end
            if (last_pair) begin
              state <= S_RESP;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_WAIT;
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status    <= status;
            rsp.peak_load <= peak_ratio;
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_busy_interval_load_meter_unit.sv @@
// Self-checking testbench for busy_interval_load_meter_unit: a scoreboard
// class tracks the ring, the open interval and the peak, and checks each response.
// Depends on bilm_pkg and the RTL of the block.
module tb_busy_interval_load_meter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bilm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS = 500;
  localparam int HOLD_CYCLES = 400;

  class load_peak_board;
    logic [TIME_W-1:0] start_ring [RING_DEPTH];
    logic [TIME_W-1:0] stop_ring [RING_DEPTH];
    int unsigned wr_idx;
    bit open_interval;
    logic [TIME_W-1:0] latched_start;
    logic [Q_W-1:0] peak;
    rsp_t expected_rsp[$];
    int unsigned mismatches;
    int unsigned rsp_count;

    function new();
      foreach (start_ring[i]) begin
        start_ring[i] = '0;
        stop_ring[i] = '0;
      end
      wr_idx = 0;
      open_interval = 1'b0;
      latched_start = '0;
      peak = '0;
      mismatches = 0;
      rsp_count = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    // Q4.12 ratio of busy time to start-to-start gap, or -1 when the pair
    // cannot raise the peak.
    function int pair_ratio_q12(logic [TIME_W-1:0] busy, logic [TIME_W-1:0] gap);
      logic [TIME_W-1:0] b_mag;
      logic [TIME_W-1:0] g_mag;
      logic [63:0] q;
      b_mag = busy[TIME_W-1] ? -busy : busy;
      g_mag = gap[TIME_W-1] ? -gap : gap;
      if (g_mag == '0) return busy[TIME_W-1] ? -1 : int'(Q_MAX);
      if (b_mag == '0 || busy[TIME_W-1] != gap[TIME_W-1]) return -1;
      q = ({32'd0, b_mag} << Q_FRAC) / {32'd0, g_mag};
      if (q > 64'(Q_MAX)) q = 64'(Q_MAX);
      return int'(q);
    endfunction

    function void take_request(req_t r);
      rsp_t e;
      int ratio;
      e.status = ST_DONE;
      case (r.command)
        CMD_START: begin
          if (open_interval) begin
            e.status = ST_START_IGNORED;
          end else begin
            latched_start = r.time_now;
            open_interval = 1'b1;
          end
        end
        CMD_STOP: begin
          if (!open_interval) begin
            e.status = ST_STOP_IGNORED;
          end else begin
            start_ring[wr_idx] = latched_start;
            stop_ring[wr_idx] = r.time_now;
            wr_idx++;
            // Wrapping the ring also clears the peak.
            if (wr_idx >= RING_DEPTH) begin
              wr_idx = 0;
              peak = '0;
            end
            open_interval = 1'b0;
          end
        end
        CMD_COMPUTE: begin
          for (int i = 0; i + 1 < RING_DEPTH; i++) begin
            ratio = pair_ratio_q12(stop_ring[i] - start_ring[i],
                                   start_ring[i+1] - start_ring[i]);
            if (ratio >= 0 && ratio > int'(peak)) peak = ratio[Q_W-1:0];
          end
        end
        default: ;
      endcase
      e.peak_load = peak;
      expected_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      rsp_count++;
      if (expected_rsp.size() == 0) begin
        report($sformatf("response %0d arrived with no request pending (status %0d peak %h)",
                         rsp_count, got.status, got.peak_load));
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status)
        report($sformatf("response %0d status %0d, want %0d",
                         rsp_count, got.status, want.status));
      if (got.peak_load !== want.peak_load)
        report($sformatf("response %0d peak_load %h, want %h",
                         rsp_count, got.peak_load, want.peak_load));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  load_peak_board board = new();
  bit quiet_phase = 1'b0;
  bit hold_rsp = 1'b0;
  logic [TIME_W-1:0] t_mark = '0;
  int unsigned items_sent = 0;

  busy_interval_load_meter_unit DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.take_request(req);
      if (rsp_valid && rsp_ready) board.check_response(rsp);
    end
  end

  // Offers one request and returns at the edge that accepts it. Valid stays
  // high afterwards unless the next request starts with a gap.
  task automatic offer(input logic [1:0] cmd, input logic [TIME_W-1:0] t);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{command: cmd, time_now: t};
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_rsp.size() != 0) @(posedge clk);
  endtask

  // One well-formed start/stop pair. The busy time and the step to the next
  // start are drawn so that zero, negative, saturating and ordinary ratios
  // all show up once the ring is full.
  task automatic run_interval();
    logic [TIME_W-1:0] busy;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] mag;
    case ($urandom_range(0, 7))
      0: busy = '0;
      1: busy = -32'($urandom_range(1, 4000));
      2: busy = $urandom;
      default: busy = $urandom_range(1, 4000);
    endcase
    mag = busy[TIME_W-1] ? -busy : busy;
    case ($urandom_range(0, 7))
      0: gap = '0;
      1: gap = -32'($urandom_range(1, 4000));
      2: gap = $urandom_range(0, mag);
      3: gap = $urandom;
      default: gap = mag + $urandom_range(0, 8000);
    endcase
    if ($urandom_range(0, 15) == 0) t_mark = $urandom;
    offer(CMD_START, t_mark);
    if ($urandom_range(0, 7) == 0) offer(CMD_START, $urandom);
    offer(CMD_STOP, t_mark + busy);
    if ($urandom_range(0, 7) == 0) offer(CMD_STOP, $urandom);
    t_mark = t_mark + gap;
  endtask

  initial begin
    bit pressed;
    int unsigned pick;
    pressed = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset every entry is zero, so the zero gap saturates the peak.
    offer(CMD_COMPUTE, '0);
    offer(CMD_STOP, '1);
    offer(CMD_UNUSED, '1);
    offer(CMD_START, '0);
    offer(CMD_START, 32'h5555_5555);
    offer(CMD_STOP, '1);
    offer(CMD_START, 32'h8000_0000);
    offer(CMD_STOP, 32'h8000_0800);
    offer(CMD_COMPUTE, 32'hAAAA_AAAA);
    offer(CMD_START, '1);
    offer(CMD_STOP, '0);
    offer(CMD_UNUSED, '0);
    offer(CMD_COMPUTE, '1);
    wait_drained();

    while (items_sent < ITEMS) begin
      if (!pressed && items_sent >= ITEMS / 2) begin
        // Drain, then stall the response side so the block backs up.
        wait_drained();
        hold_rsp = 1'b1;
        while (rsp_ready) @(posedge clk);
        repeat (3) run_interval();
        pressed = 1'b1;
      end
      quiet_phase = (items_sent >= ITEMS - 60);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        offer(2'($urandom_range(0, 3)), $urandom);
      end else if (pick <= 2) begin
        offer(CMD_COMPUTE, $urandom);
      end else begin
        run_interval();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.expected_rsp.size() == 0) begin
      $display("tb_busy_interval_load_meter_unit passed");
    end else begin
      $display("tb_busy_interval_load_meter_unit failed");
    end
    $finish;
  end

  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    #15ms;
    $display("tb_busy_interval_load_meter_unit failed");
    $finish;
  end

endmodule
